[rtl/bru_pkg.sv]
// ----------------------------------------------------------------------------
// bru_pkg
// Types, constants and register indexes shared by the row pixel unpacker.
// ----------------------------------------------------------------------------
package bru_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int PALETTE_DEPTH = 256;
   localparam int OUT_DEPTH     = 4;

   localparam int DIM_W    = 13;                  // width and height registers
   localparam int COORD_W  = 12;                  // pixel coordinates
   localparam int ROWPOS_W = 15;                  // byte position within a row
   localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
   localparam int COLOR_W  = 24;
   localparam int OUT_AW   = $clog2(OUT_DEPTH);
   localparam int OUT_CW   = $clog2(OUT_DEPTH + 1);

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_DEPTH_MODE   = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // Depth mode codes; codes above MODE_BPP32 disable decoding.
   localparam logic [2:0] MODE_BPP1  = 3'd0;
   localparam logic [2:0] MODE_BPP4  = 3'd1;
   localparam logic [2:0] MODE_BPP8  = 3'd2;
   localparam logic [2:0] MODE_BPP24 = 3'd3;
   localparam logic [2:0] MODE_BPP32 = 3'd4;

   localparam logic       REQ_PALETTE = 1'b0;
   localparam logic       REQ_DATA    = 1'b1;

   // One data byte's worth of pixels, handed from the position tracker to
   // the expander.
   typedef struct packed {
      logic [7:0]         data;
      logic [2:0]         mode;
      logic [COORD_W-1:0] col;
      logic [3:0]         count;
      logic [COORD_W-1:0] row;
      logic [COLOR_W-1:0] color;
      logic [7:0]         alpha;
      logic               direct;
   } job_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [7:0]         chan0;
      logic [7:0]         chan1;
      logic [7:0]         chan2;
      logic [7:0]         alpha;
      logic               last_of_run;
      logic               image_done;
   } pixel_type;

endpackage

[rtl/bru_req_if.sv]
// ----------------------------------------------------------------------------
// bru_req_if
// Input channel: palette entry writes and pixel array bytes.
// ----------------------------------------------------------------------------
interface bru_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [7:0]  palette_index;
   logic [23:0] palette_color;
   logic [7:0]  data_byte;

   modport source (output valid, req_type, palette_index, palette_color, data_byte,
                   input ready);
   modport sink   (input valid, req_type, palette_index, palette_color, data_byte,
                   output ready);
endinterface

[rtl/bru_rsp_if.sv]
// ----------------------------------------------------------------------------
// bru_rsp_if
// Result channel: one decoded pixel per word.
// ----------------------------------------------------------------------------
interface bru_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   logic [7:0]  chan0;
   logic [7:0]  chan1;
   logic [7:0]  chan2;
   logic [7:0]  alpha;
   logic        last_of_run;
   logic        image_done;

   modport source (output valid, pixel_x, pixel_y, chan0, chan1, chan2, alpha,
                          last_of_run, image_done,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, chan0, chan1, chan2, alpha,
                         last_of_run, image_done,
                   output ready);
endinterface

[rtl/bmp_row_pixel_unpacker.sv]
// ----------------------------------------------------------------------------
// bmp_row_pixel_unpacker
// Decodes a bottom-up DIB pixel array, byte by byte, into pixel words.
// ----------------------------------------------------------------------------
// Usage: write depth mode, width and height on the csr_ port while the block
// is idle; any register write restarts the stream at the bottom row and
// keeps the palette. On req_ch, a word with req_type 0 writes one palette
// entry; a word with req_type 1 carries the next byte of the padded array.
// Each pixel leaves on rsp_ch as one word, last_of_run marking the last
// pixel of a byte and image_done the last pixel of the top row.
// Throughput: one pixel word per cycle while the output queue has room,
// set by the single palette read port and the expander that issues one
// lookup a cycle. A new byte is taken once the last pixel of the previous
// byte is issued; padding bytes and palette writes need no lookup.
// Pixels of a byte pass the job register and palette read stage into a
// four-word output queue that absorbs stalls; while rsp_ch.ready is low
// the queue fills, issue stops and req_ch.ready stays low while a byte is held.
// Reset sets 8 bpp, a 1 by 1 image and an empty pipeline; the palette holds
// no defined contents until written.
// ----------------------------------------------------------------------------
module bmp_row_pixel_unpacker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata,
   bru_req_if.sink     req_ch,
   bru_rsp_if.source   rsp_ch
);
   import bru_pkg::*;

   logic [2:0]         depth_mode_ff;
   logic [DIM_W-1:0]   image_width_ff;
   logic [DIM_W-1:0]   image_height_ff;
   logic [DIM_W-1:0]   height_src;
   logic [DIM_W-1:0]   eff_width;
   logic [DIM_W-1:0]   eff_height;
   logic               restart;

   logic               accept;
   logic               byte_acc;
   logic               pal_wr;
   logic               job_valid;
   job_type            job;
   logic               free;
   logic [PAL_AW-1:0]  rd_addr;
   logic [COLOR_W-1:0] rd_data;
   logic               push;
   pixel_type          push_pix;
   logic [OUT_CW-1:0]  out_count;

   always_comb begin
      if (image_width_ff == '0) begin
         eff_width = DIM_W'(1);
      end else if (image_width_ff > DIM_W'(MAX_WIDTH)) begin
         eff_width = DIM_W'(MAX_WIDTH);
      end else begin
         eff_width = image_width_ff;
      end
      // The restart row must follow a height that is written in this cycle.
      height_src = (csr_we && (csr_index == CSR_IMAGE_HEIGHT)) ? csr_wdata
                                                               : image_height_ff;
      if (height_src == '0) begin
         eff_height = DIM_W'(1);
      end else if (height_src > DIM_W'(MAX_HEIGHT)) begin
         eff_height = DIM_W'(MAX_HEIGHT);
      end else begin
         eff_height = height_src;
      end
      restart = csr_we && ((csr_index == CSR_DEPTH_MODE) ||
                           (csr_index == CSR_IMAGE_WIDTH) ||
                           (csr_index == CSR_IMAGE_HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_mode_ff   <= MODE_BPP8;
         image_width_ff  <= DIM_W'(1);
         image_height_ff <= DIM_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEPTH_MODE:   depth_mode_ff   <= csr_wdata[2:0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // A new word is taken once the expander has issued the last pixel of the
   // previous byte, so palette writes never overtake earlier lookups.
   assign req_ch.ready = free;
   assign accept       = req_ch.valid && free;
   assign byte_acc     = accept && (req_ch.req_type == REQ_DATA);
   assign pal_wr       = accept && (req_ch.req_type == REQ_PALETTE);

   bru_stream_pos u_pos (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .byte_acc   (byte_acc),
      .data_byte  (req_ch.data_byte),
      .mode       (depth_mode_ff),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .job_valid  (job_valid),
      .job        (job)
   );

   bru_palette_ram u_pal (
      .clock   (clock),
      .wr_en   (pal_wr),
      .wr_addr (req_ch.palette_index),
      .wr_data (req_ch.palette_color),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bru_expander u_exp (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .eff_width (eff_width),
      .out_count (out_count),
      .free      (free),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .push      (push),
      .push_pix  (push_pix)
   );

   bru_out_buf u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_pix (push_pix),
      .count    (out_count),
      .rsp_ch   (rsp_ch)
   );

endmodule

[rtl/bru_palette_ram.sv]
// ----------------------------------------------------------------------------
// bru_palette_ram
// Palette store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module bru_palette_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [bru_pkg::PAL_AW-1:0]    wr_addr,
   input  logic [bru_pkg::COLOR_W-1:0]   wr_data,
   input  logic [bru_pkg::PAL_AW-1:0]    rd_addr,
   output logic [bru_pkg::COLOR_W-1:0]   rd_data
);
   import bru_pkg::*;

   logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;

   // A read of the entry being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bru_stream_pos.sv]
// ----------------------------------------------------------------------------
// bru_stream_pos
// Tracks the position in the padded pixel array and turns each data byte
// into a run of pixels for the expander.
// ----------------------------------------------------------------------------
module bru_stream_pos (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        restart,
   input  logic                        byte_acc,
   input  logic [7:0]                  data_byte,
   input  logic [2:0]                  mode,
   input  logic [bru_pkg::DIM_W-1:0]   eff_width,
   input  logic [bru_pkg::DIM_W-1:0]   eff_height,
   output logic                        job_valid,
   output bru_pkg::job_type            job
);
   import bru_pkg::*;

   logic [ROWPOS_W-1:0] row_byte_pos_ff, row_byte_pos_in;
   logic [COORD_W-1:0]  current_row_ff, current_row_in;
   logic [DIM_W-1:0]    next_column_ff, next_column_in;
   logic [1:0]          byte_phase_ff, byte_phase_in;
   logic [COLOR_W-1:0]  gathered_ff, gathered_in;
   logic                frame_finished_ff, frame_finished_in;

   logic [17:0]         row_bits;
   logic [17:0]         row_bits_up;
   logic [ROWPOS_W-1:0] row_len;
   logic [ROWPOS_W:0]   pos_next;
   logic [DIM_W-1:0]    remaining;
   logic                in_row;
   logic                active;
   logic [3:0]          count;
   logic [COLOR_W-1:0]  gather_merge;

   // Bits in one row, then rounded up to whole 32-bit words.
   always_comb begin
      unique case (mode)
         MODE_BPP1:  row_bits = 18'(eff_width);
         MODE_BPP4:  row_bits = 18'(eff_width) << 2;
         MODE_BPP8:  row_bits = 18'(eff_width) << 3;
         MODE_BPP24: row_bits = (18'(eff_width) << 4) + (18'(eff_width) << 3);
         default:    row_bits = 18'(eff_width) << 5;
      endcase
      row_bits_up = row_bits + 18'd31;
      row_len     = {row_bits_up[17:5], 2'b00};
   end

   always_comb begin
      active    = byte_acc && !frame_finished_ff && (mode <= MODE_BPP32);
      in_row    = next_column_ff < eff_width;
      remaining = eff_width - next_column_ff;
      pos_next  = {1'b0, row_byte_pos_ff} + 1'b1;

      unique case (byte_phase_ff)
         2'd0:    gather_merge = gathered_ff | {16'd0, data_byte};
         2'd1:    gather_merge = gathered_ff | {8'd0, data_byte, 8'd0};
         default: gather_merge = gathered_ff | {data_byte, 16'd0};
      endcase

      count = 4'd0;
      if (in_row) begin
         unique case (mode)
            MODE_BPP1:  count = (remaining >= DIM_W'(8)) ? 4'd8 : remaining[3:0];
            MODE_BPP4:  count = (remaining >= DIM_W'(2)) ? 4'd2 : 4'd1;
            MODE_BPP8:  count = 4'd1;
            MODE_BPP24: count = (byte_phase_ff >= 2'd2) ? 4'd1 : 4'd0;
            default:    count = (byte_phase_ff == 2'd3) ? 4'd1 : 4'd0;
         endcase
      end

      job.data   = data_byte;
      job.mode   = mode;
      job.col    = next_column_ff[COORD_W-1:0];
      job.count  = count;
      job.row    = current_row_ff;
      job.direct = (mode == MODE_BPP24) || (mode == MODE_BPP32);
      if (mode == MODE_BPP24) begin
         job.color = {data_byte, gathered_ff[15:0]};
         job.alpha = 8'hff;
      end else if (mode == MODE_BPP32) begin
         job.color = gathered_ff;
         job.alpha = data_byte;
      end else begin
         job.color = gathered_ff;
         job.alpha = 8'hff;
      end
      job_valid = active && (count != 4'd0);

      row_byte_pos_in   = row_byte_pos_ff;
      current_row_in    = current_row_ff;
      next_column_in    = next_column_ff;
      byte_phase_in     = byte_phase_ff;
      gathered_in       = gathered_ff;
      frame_finished_in = frame_finished_ff;

      if (restart) begin
         row_byte_pos_in   = '0;
         current_row_in    = COORD_W'(eff_height - 1'b1);
         next_column_in    = '0;
         byte_phase_in     = '0;
         gathered_in       = '0;
         frame_finished_in = 1'b0;
      end else if (active) begin
         next_column_in = next_column_ff + DIM_W'(count);
         if (in_row && job.direct) begin
            if (count != 4'd0) begin
               byte_phase_in = '0;
               gathered_in   = '0;
            end else begin
               byte_phase_in = byte_phase_ff + 1'b1;
               gathered_in   = gather_merge;
            end
         end
         if (pos_next >= {1'b0, row_len}) begin
            row_byte_pos_in = '0;
            next_column_in  = '0;
            byte_phase_in   = '0;
            gathered_in     = '0;
            if (current_row_ff == '0) begin
               frame_finished_in = 1'b1;
            end else begin
               current_row_in = current_row_ff - 1'b1;
            end
         end else begin
            row_byte_pos_in = pos_next[ROWPOS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_byte_pos_ff   <= '0;
         current_row_ff    <= '0;
         next_column_ff    <= '0;
         byte_phase_ff     <= '0;
         gathered_ff       <= '0;
         frame_finished_ff <= 1'b0;
      end else begin
         row_byte_pos_ff   <= row_byte_pos_in;
         current_row_ff    <= current_row_in;
         next_column_ff    <= next_column_in;
         byte_phase_ff     <= byte_phase_in;
         gathered_ff       <= gathered_in;
         frame_finished_ff <= frame_finished_in;
      end
   end

endmodule

[rtl/bru_expander.sv]
// ----------------------------------------------------------------------------
// bru_expander
// Steps through the pixels of one run, one a cycle while the output buffer
// has room, looks each index up in the palette (direct colours pass through)
// and forms the finished pixel in the cycle after the lookup.
module bru_expander (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  bru_pkg::job_type              job,
   input  logic [bru_pkg::DIM_W-1:0]     eff_width,
   input  logic [bru_pkg::OUT_CW-1:0]    out_count,
   output logic                          free,
   output logic [bru_pkg::PAL_AW-1:0]    rd_addr,
   input  logic [bru_pkg::COLOR_W-1:0]   rd_data,
   output logic                          push,
   output bru_pkg::pixel_type            push_pix
);
   import bru_pkg::*;

   job_type         job_ff, job_in;
   logic            busy_ff, busy_in;
   logic [2:0]      step_ff, step_in;
   logic            s2_valid_ff;
   pixel_type       s2_pix_ff;
   logic            s2_pal_ff;

   logic            issue;
   logic            last;
   logic [OUT_CW:0] in_flight;
   logic [COORD_W-1:0] col;
   pixel_type       issue_pix;

   always_comb begin
      // Issue only when the output buffer is sure to have room for every
      // word already in the palette read stage plus this one.
      in_flight = {1'b0, out_count} + (OUT_CW + 1)'(s2_valid_ff);
      issue     = busy_ff && (in_flight < (OUT_CW + 1)'(OUT_DEPTH));
      last      = issue && (({1'b0, step_ff} + 4'd1) == job_ff.count);
      free      = !busy_ff || last;
      col       = job_ff.col + COORD_W'(step_ff);

      unique case (job_ff.mode)
         MODE_BPP1: rd_addr = PAL_AW'(job_ff.data[3'd7 - step_ff]);
         MODE_BPP4: rd_addr = (step_ff == 3'd0) ? PAL_AW'(job_ff.data[7:4])
                                                : PAL_AW'(job_ff.data[3:0]);
         default:   rd_addr = PAL_AW'(job_ff.data);
      endcase

      issue_pix.pixel_x     = col;
      issue_pix.pixel_y     = job_ff.row;
      issue_pix.chan0       = job_ff.color[7:0];
      issue_pix.chan1       = job_ff.color[15:8];
      issue_pix.chan2       = job_ff.color[23:16];
      issue_pix.alpha       = job_ff.alpha;
      issue_pix.last_of_run = last;
      issue_pix.image_done  = (job_ff.row == '0) &&
                              (({1'b0, col} + 1'b1) == eff_width);

      job_in  = job_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (job_valid) begin
         job_in  = job;
         busy_in = 1'b1;
         step_in = '0;
      end else if (last) begin
         busy_in = 1'b0;
      end else if (issue) begin
         step_in = step_ff + 1'b1;
      end

      push     = s2_valid_ff;
      push_pix = s2_pix_ff;
      if (s2_pal_ff) begin
         push_pix.chan0 = rd_data[7:0];
         push_pix.chan1 = rd_data[15:8];
         push_pix.chan2 = rd_data[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         step_ff     <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         step_ff     <= step_in;
         s2_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      s2_pix_ff <= issue_pix;
      s2_pal_ff <= !job_ff.direct;
   end

endmodule

[rtl/bru_out_buf.sv]
// ----------------------------------------------------------------------------
// bru_out_buf
// Small output queue that decouples the pixel pipeline from the receiver.
// ----------------------------------------------------------------------------
module bru_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bru_pkg::pixel_type          push_pix,
   output logic [bru_pkg::OUT_CW-1:0]  count,
   bru_rsp_if.source                   rsp_ch
);
   import bru_pkg::*;

   pixel_type          slots [OUT_DEPTH];
   logic [OUT_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [OUT_CW-1:0]  count_ff, count_in;
   logic               pop;
   pixel_type          head;

   always_comb begin
      head     = slots[rd_ptr_ff];
      pop      = rsp_ch.valid && rsp_ch.ready;
      count_in = count_ff + OUT_CW'(push) - OUT_CW'(pop);
   end

   assign rsp_ch.valid       = (count_ff != '0);
   assign rsp_ch.pixel_x     = head.pixel_x;
   assign rsp_ch.pixel_y     = head.pixel_y;
   assign rsp_ch.chan0       = head.chan0;
   assign rsp_ch.chan1       = head.chan1;
   assign rsp_ch.chan2       = head.chan2;
   assign rsp_ch.alpha       = head.alpha;
   assign rsp_ch.last_of_run = head.last_of_run;
   assign rsp_ch.image_done  = head.image_done;
   assign count              = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_pix;
      end
   end

endmodule
